@@ rtl/ptsb_pkg.sv @@
// Shared types and constants for the point-to-scan minimum-range binner.
// Used by the CORDIC cell, the divider and the top level; depends on nothing.
`timescale 1ns / 1ps
package ptsb_pkg;

  localparam int CORD_STEPS = 24;
  localparam int CORD_XW    = 44;
  localparam int CORD_ZW    = 34;
  localparam int DIV_NW     = 20;
  localparam int DIV_DW     = 18;

  localparam logic signed [CORD_ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [19:0]        PI_Q16 = 20'sd205887;

  localparam logic [31:0] ATAN_Q30 [CORD_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128
  };

  localparam logic [2:0] CFG_MIN_HEIGHT    = 3'd0;
  localparam logic [2:0] CFG_MAX_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_RANGE_FLOOR   = 3'd2;
  localparam logic [2:0] CFG_RANGE_CEILING = 3'd3;
  localparam logic [2:0] CFG_ANGLE_START   = 3'd4;
  localparam logic [2:0] CFG_ANGLE_STOP    = 3'd5;
  localparam logic [2:0] CFG_ANGLE_STEP    = 3'd6;
  localparam logic [2:0] CFG_EMPTY_FILL    = 3'd7;

  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic              point_invalid;
    logic [8:0]        read_bin;
  } in_t;

  typedef struct packed {
    logic [8:0]  bin_number;
    logic [23:0] bin_range;
    logic        no_return;
  } res_t;

  typedef struct packed {
    logic                      vld;
    logic                      zero;
    logic signed [CORD_XW-1:0] x;
    logic signed [CORD_XW-1:0] y;
    logic signed [CORD_ZW-1:0] z;
  } cord_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_MUL, ST_SUM, ST_SQRT, ST_CHK, ST_DIVL, ST_DIVI,
    ST_UPD
  } st_t;

endpackage

@@ rtl/point_to_scan_min_range_binner_unit.sv @@
// Top level of the point-to-scan minimum-range binner: sequencer, square root,
// bin store and CORDIC cell chain. Depends on ptsb_pkg, ptsb_cordic_cell, ptsb_div.
//
//   channel  ports                           handshake
//   input    start, busy, in_data            beat when start && !busy
//   result   out_valid, out_data             one-cycle strobe, no stall
//   config   cfg_valid, cfg_ready, cfg_*     beat when valid && ready
//
// A read item passes through ST_RD and its result is registered from there. An
// accumulate item runs setup (ST_MUL, ST_SUM), 24 square-root steps, a check and
// two divisions for the bin index, then a bin read-modify-write; a point dropped
// at input stays idle. After reset the bin store is cleared one bin a cycle, with
// busy high. The result side cannot stall, so results are never held back.
`timescale 1ns / 1ps
module point_to_scan_min_range_binner_unit #(
  parameter int BIN_COUNT = 512
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ptsb_pkg::in_t  in_data,
  output logic           out_valid,
  output ptsb_pkg::res_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data
);

  localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int CNT_W = $clog2(BIN_COUNT + 1);

  ptsb_pkg::st_t state_r, state_nxt;

  // configuration
  logic signed [23:0] min_h_r, max_h_r;
  logic [23:0]        floor_r, ceil_r, fill_r;
  logic signed [18:0] a0_r, a1_r;
  logic [17:0]        step_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_h_r    <= 24'sh800000;
      max_h_r    <= 24'sh7FFFFF;
      floor_r    <= '0;
      ceil_r     <= 24'hFFFFFF;
      a0_r       <= -19'sd205887;
      a1_r       <= 19'sd205887;
      step_cfg_r <= 18'd1144;
      fill_r     <= 24'hFFFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ptsb_pkg::CFG_MIN_HEIGHT:    min_h_r    <= cfg_data;
        ptsb_pkg::CFG_MAX_HEIGHT:    max_h_r    <= cfg_data;
        ptsb_pkg::CFG_RANGE_FLOOR:   floor_r    <= cfg_data;
        ptsb_pkg::CFG_RANGE_CEILING: ceil_r     <= cfg_data;
        ptsb_pkg::CFG_ANGLE_START:   a0_r       <= cfg_data[18:0];
        ptsb_pkg::CFG_ANGLE_STOP:    a1_r       <= cfg_data[18:0];
        ptsb_pkg::CFG_ANGLE_STEP:    step_cfg_r <= cfg_data[17:0];
        ptsb_pkg::CFG_EMPTY_FILL:    fill_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // captured item and datapath registers
  logic               accept;
  logic [8:0]         bin_r;
  logic               inr_r;
  logic signed [23:0] x_r, y_r;
  logic signed [47:0] xx_r, yy_r;
  logic [47:0]        s_r;
  logic [48:0]        r_r, bit_r;
  logic [4:0]         sq_cnt_r;
  logic signed [18:0] ang_r;
  logic [23:0]        rf_r;
  logic [18:0]        diff_r;
  logic [CNT_W-1:0]   len_r;
  logic [IDX_W-1:0]   idx_r, clr_cnt_r, rd_addr;
  logic [24:0]        mem_q;
  logic [24:0]        mem [BIN_COUNT];
  logic               pt_drop;

  assign accept  = start && !busy;
  assign pt_drop = in_data.point_invalid || (in_data.point_z > max_h_r) ||
                   (in_data.point_z < min_h_r);

  // CORDIC cell chain
  ptsb_pkg::cord_t chain [ptsb_pkg::CORD_STEPS+1];
  logic            x_neg;

  assign x_neg = x_r[23];

  always_comb begin
    chain[0].vld  = (state_r == ptsb_pkg::ST_MUL);
    chain[0].zero = (x_r == '0) && (y_r == '0);
    chain[0].x    = {{4{x_r[23]}}, x_r, 16'b0};
    chain[0].y    = {{4{y_r[23]}}, y_r, 16'b0};
    chain[0].z    = '0;
    if (x_neg) begin
      chain[0].x = -chain[0].x;
      chain[0].y = -chain[0].y;
      chain[0].z = y_r[23] ? -ptsb_pkg::PI_Q30 : ptsb_pkg::PI_Q30;
    end
  end

  for (genvar g = 0; g < ptsb_pkg::CORD_STEPS; g++) begin : g_cell
    ptsb_cordic_cell #(.STEP(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_in (chain[g]),
      .cell_out(chain[g+1])
    );
  end

  logic signed [ptsb_pkg::CORD_ZW-1:0] z_rnd;
  logic signed [19:0]                  q_ang;
  logic signed [18:0]                  ang_nxt;

  assign z_rnd = (chain[ptsb_pkg::CORD_STEPS].z + 34'sd8192) >>> 14;
  assign q_ang = 20'(z_rnd);

  always_comb begin
    if (chain[ptsb_pkg::CORD_STEPS].zero) begin
      ang_nxt = '0;
    end else if (q_ang > ptsb_pkg::PI_Q16) begin
      ang_nxt = 19'(ptsb_pkg::PI_Q16);
    end else if (q_ang < -ptsb_pkg::PI_Q16) begin
      ang_nxt = 19'(-ptsb_pkg::PI_Q16);
    end else begin
      ang_nxt = 19'(q_ang);
    end
  end

  // check stage
  logic [24:0]        rf;
  logic               rng_bad, ang_bad;
  logic [19:0]        span_s;
  logic [17:0]        step_e;
  logic [19:0]        lnum;

  assign rf      = 25'(r_r) + 25'(s_r > 48'(r_r));
  assign rng_bad = (rf < {1'b0, floor_r}) || (rf > {1'b0, ceil_r});
  assign ang_bad = (ang_r < a0_r) || (ang_r > a1_r);
  assign span_s  = 20'({a1_r[18], a1_r} - {a0_r[18], a0_r});
  assign step_e  = (step_cfg_r == '0) ? 18'd1 : step_cfg_r;
  assign lnum    = (span_s == '0) ? '0 : span_s + 20'(step_e) - 20'd1;

  // divider
  logic        div_go, div_done;
  logic [19:0] div_num, div_q;

  assign div_go  = ((state_r == ptsb_pkg::ST_CHK) && !rng_bad && !ang_bad) ||
                   ((state_r == ptsb_pkg::ST_DIVL) && div_done);
  assign div_num = (state_r == ptsb_pkg::ST_CHK) ? lnum : {1'b0, diff_r};

  ptsb_div u_div (
    .clk (clk),
    .rst_n(rst_n),
    .go  (div_go),
    .num (div_num),
    .den (step_e),
    .done(div_done),
    .quo (div_q)
  );

  logic [CNT_W-1:0] len_nxt;
  logic [IDX_W-1:0] idx_nxt;

  always_comb begin
    if (div_q == '0) begin
      len_nxt = CNT_W'(1);
    end else if (32'(div_q) > BIN_COUNT) begin
      len_nxt = CNT_W'(BIN_COUNT);
    end else begin
      len_nxt = CNT_W'(div_q);
    end
    if (32'(div_q) >= 32'(len_r)) begin
      idx_nxt = IDX_W'(len_r - CNT_W'(1));
    end else begin
      idx_nxt = IDX_W'(div_q);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptsb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptsb_pkg::ST_CLEAR:
        if (clr_cnt_r == IDX_W'(BIN_COUNT - 1)) state_nxt = ptsb_pkg::ST_IDLE;
      ptsb_pkg::ST_IDLE:
        if (accept) begin
          if (in_data.req_type == ptsb_pkg::REQ_READ) begin
            state_nxt = ptsb_pkg::ST_RD;
          end else if (!pt_drop) begin
            state_nxt = ptsb_pkg::ST_MUL;
          end
        end
      ptsb_pkg::ST_RD:   state_nxt = ptsb_pkg::ST_IDLE;
      ptsb_pkg::ST_MUL:  state_nxt = ptsb_pkg::ST_SUM;
      ptsb_pkg::ST_SUM:  state_nxt = ptsb_pkg::ST_SQRT;
      ptsb_pkg::ST_SQRT:
        if (sq_cnt_r == '0) state_nxt = ptsb_pkg::ST_CHK;
      ptsb_pkg::ST_CHK:
        state_nxt = (rng_bad || ang_bad) ? ptsb_pkg::ST_IDLE : ptsb_pkg::ST_DIVL;
      ptsb_pkg::ST_DIVL:
        if (div_done) state_nxt = ptsb_pkg::ST_DIVI;
      ptsb_pkg::ST_DIVI:
        if (div_done) state_nxt = ptsb_pkg::ST_UPD;
      ptsb_pkg::ST_UPD:  state_nxt = ptsb_pkg::ST_IDLE;
      default:           state_nxt = ptsb_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != ptsb_pkg::ST_IDLE);

  always_comb begin
    if (state_r == ptsb_pkg::ST_DIVI) begin
      rd_addr = idx_nxt;
    end else begin
      rd_addr = IDX_W'(in_data.read_bin);
    end
  end

  // clear counter and result strobe
  logic out_valid_r;
  ptsb_pkg::res_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ptsb_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      out_valid_r <= (state_r == ptsb_pkg::ST_RD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ptsb_pkg::ST_RD) begin
      out_data_r.bin_number <= bin_r;
      if (inr_r && mem_q[24]) begin
        out_data_r.bin_range <= mem_q[23:0];
        out_data_r.no_return <= 1'b0;
      end else begin
        out_data_r.bin_range <= fill_r;
        out_data_r.no_return <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      bin_r <= in_data.read_bin;
      inr_r <= 32'(in_data.read_bin) < BIN_COUNT;
      x_r   <= in_data.point_x;
      y_r   <= in_data.point_y;
    end
    if (state_r == ptsb_pkg::ST_MUL) begin
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
    end
    if (state_r == ptsb_pkg::ST_SUM) begin
      s_r      <= 48'(xx_r) + 48'(yy_r);
      r_r      <= '0;
      bit_r    <= 49'd1 << 46;
      sq_cnt_r <= 5'd23;
    end
    if (state_r == ptsb_pkg::ST_SQRT) begin
      if (49'(s_r) >= r_r + bit_r) begin
        s_r <= 48'(49'(s_r) - (r_r + bit_r));
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r    <= bit_r >> 2;
      sq_cnt_r <= sq_cnt_r - 5'd1;
    end
    if (chain[ptsb_pkg::CORD_STEPS].vld) ang_r <= ang_nxt;
    if (state_r == ptsb_pkg::ST_CHK) begin
      rf_r   <= rf[23:0];
      diff_r <= 19'({ang_r[18], ang_r} - {a0_r[18], a0_r});
    end
    if ((state_r == ptsb_pkg::ST_DIVL) && div_done) len_r <= len_nxt;
    if ((state_r == ptsb_pkg::ST_DIVI) && div_done) idx_r <= idx_nxt;
  end

  // bin store: occupied flag over the minimum range
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    priority if (state_r == ptsb_pkg::ST_CLEAR) begin
      mem[clr_cnt_r] <= {1'b0, 24'hFFFFFF};
    end else if ((state_r == ptsb_pkg::ST_RD) && inr_r) begin
      mem[IDX_W'(bin_r)] <= {1'b0, 24'hFFFFFF};
    end else if ((state_r == ptsb_pkg::ST_UPD) &&
                 (!mem_q[24] || (rf_r < mem_q[23:0]))) begin
      mem[idx_r] <= {1'b1, rf_r};
    end else begin
    end
  end

endmodule

@@ rtl/ptsb_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation, registered; cells chain into a pipeline.
// Depends on ptsb_pkg for the cell record type and the arctangent table.
`timescale 1ns / 1ps
module ptsb_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ptsb_pkg::cord_t cell_in,
  output ptsb_pkg::cord_t cell_out
);

  ptsb_pkg::cord_t cell_r, cell_nxt;
  logic signed [ptsb_pkg::CORD_ZW-1:0] atan_c;

  assign atan_c = ptsb_pkg::CORD_ZW'(ptsb_pkg::ATAN_Q30[STEP]);

  always_comb begin
    cell_nxt = cell_in;
    if (cell_in.y > 0) begin
      cell_nxt.x = cell_in.x + (cell_in.y >>> STEP);
      cell_nxt.y = cell_in.y - (cell_in.x >>> STEP);
      cell_nxt.z = cell_in.z + atan_c;
    end else begin
      cell_nxt.x = cell_in.x - (cell_in.y >>> STEP);
      cell_nxt.y = cell_in.y + (cell_in.x >>> STEP);
      cell_nxt.z = cell_in.z - atan_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_in.vld;
    end
    cell_r.zero <= cell_nxt.zero;
    cell_r.x    <= cell_nxt.x;
    cell_r.y    <= cell_nxt.y;
    cell_r.z    <= cell_nxt.z;
  end

  assign cell_out = cell_r;

endmodule

@@ rtl/ptsb_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ptsb_pkg for the operand widths.
`timescale 1ns / 1ps
module ptsb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [ptsb_pkg::DIV_NW-1:0] num,
  input  logic [ptsb_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [ptsb_pkg::DIV_NW-1:0] quo
);

  logic [ptsb_pkg::DIV_NW-1:0] nq_r;
  logic [ptsb_pkg::DIV_DW-1:0] rem_r, den_r;
  logic [4:0]                  cnt_r;
  logic                        run_r, done_r;
  logic [ptsb_pkg::DIV_DW:0]   trial;
  logic                        fits;

  assign trial = {rem_r, nq_r[ptsb_pkg::DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 5'(ptsb_pkg::DIV_NW - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (go) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= fits ? ptsb_pkg::DIV_DW'(trial - {1'b0, den_r})
                    : ptsb_pkg::DIV_DW'(trial);
      nq_r  <= {nq_r[ptsb_pkg::DIV_NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for point_to_scan_min_range_binner_unit.
// Predicts each bin read from its own model of the range, angle and bin store.
// Depends on ptsb_pkg and the top level of the binner.
`timescale 1ns / 1ps
module testbench;

  localparam logic REQ_POINT  = 1'b0;
  localparam int   BINS       = 512;
  localparam int   SETTLE     = 100;
  localparam int   PHASES     = 7;
  localparam int   PER_PHASE  = 175;
  localparam int   IN_W       = $bits(ptsb_pkg::in_t);

  typedef struct {
    ptsb_pkg::in_t d;
    bit            drain;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ptsb_pkg::in_t  in_data = '0;
  logic out_valid;
  ptsb_pkg::res_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = ptsb_pkg::CFG_MIN_HEIGHT;
  logic [23:0] cfg_data = '0;

  // Model copy of the registers and the bin store.
  logic signed [23:0] min_h, max_h;
  logic [23:0] rng_lo, rng_hi, fill_val;
  logic signed [18:0] ang_lo, ang_hi;
  logic [17:0] ang_step;
  logic [23:0] bin_min [BINS];
  bit bin_full [BINS];

  beat_t          pending_items[$];
  ptsb_pkg::res_t expected_bins[$];
  int    gap_left = 0;
  int    mismatches = 0;
  bit    no_idle = 0;

  point_to_scan_min_range_binner_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [23:0] planar_range(longint x, longint y);
    longint unsigned s, r, b;
    s = longint'(x * x) + longint'(y * y);
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r++;
    return r[23:0];
  endfunction

  function automatic longint planar_angle(longint x, longint y);
    longint cx, cy, z, nx, ny, q;
    cx = x * 65536;
    cy = y * 65536;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(ptsb_pkg::PI_Q30) : -longint'(ptsb_pkg::PI_Q30);
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < ptsb_pkg::CORD_STEPS; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z = z + longint'(ptsb_pkg::ATAN_Q30[i]);
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z = z - longint'(ptsb_pkg::ATAN_Q30[i]);
      end
      cx = nx;
      cy = ny;
    end
    q = (z + 8192) >>> 14;
    if (q > 205887) q = 205887;
    if (q < -205887) q = -205887;
    return q;
  endfunction

  function automatic void reset_model();
    min_h = 24'sh800000;
    max_h = 24'sh7FFFFF;
    rng_lo = '0;
    rng_hi = '1;
    ang_lo = -19'sd205887;
    ang_hi = 19'sd205887;
    ang_step = 18'd1144;
    fill_val = '1;
    for (int i = 0; i < BINS; i++) begin
      bin_min[i] = '1;
      bin_full[i] = 0;
    end
  endfunction

  // Applies one accepted beat to the bin store; a read queues its expected result.
  function automatic void bin_update(ptsb_pkg::in_t it);
    longint a, a0, a1, stp, span, len, idx;
    logic [23:0] r;
    ptsb_pkg::res_t e;
    if (it.req_type == ptsb_pkg::REQ_READ) begin
      e.bin_number = it.read_bin;
      e.bin_range = bin_full[it.read_bin] ? bin_min[it.read_bin] : fill_val;
      e.no_return = !bin_full[it.read_bin];
      expected_bins.push_back(e);
      bin_full[it.read_bin] = 0;
      bin_min[it.read_bin] = '1;
      return;
    end
    if (it.point_invalid) return;
    if (it.point_z > max_h || it.point_z < min_h) return;
    r = planar_range(it.point_x, it.point_y);
    if (r < rng_lo || r > rng_hi) return;
    a = planar_angle(it.point_x, it.point_y);
    a0 = ang_lo;
    a1 = ang_hi;
    if (a < a0 || a > a1) return;
    stp = (ang_step == 0) ? 1 : longint'(ang_step);
    span = a1 - a0;
    len = (span > 0) ? (span + stp - 1) / stp : 0;
    if (len > BINS) len = BINS;
    if (len < 1) len = 1;
    idx = (a - a0) / stp;
    if (idx >= len) idx = len - 1;
    if (!bin_full[idx] || r < bin_min[idx]) begin
      bin_min[idx] = r;
      bin_full[idx] = 1;
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents queued beats, idles at random and honors drain requests.
  always @(posedge clk) begin : drive
    int g;
    bit taken;
    taken = start && !busy;
    g = gap_left;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        bin_update(in_data);
        void'(pending_items.pop_front());
        g = pick_gap();
      end
      if (taken || !start) begin
        if (g > 0) begin
          start <= 1'b0;
          gap_left <= g - 1;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain || expected_bins.size() == 0)) begin
          in_data <= pending_items[0].d;
          start <= 1'b1;
          gap_left <= 0;
        end else begin
          start <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest expected bin read.
  always @(posedge clk) begin : watch
    ptsb_pkg::res_t e;
    if (rst_n && out_valid) begin
      if (expected_bins.size() == 0) begin
        report($sformatf("unexpected result for bin %0d", out_data.bin_number));
      end else begin
        e = expected_bins.pop_front();
        if (out_data.bin_number !== e.bin_number)
          report($sformatf("bin_number %0d, want %0d", out_data.bin_number, e.bin_number));
        if (out_data.bin_range !== e.bin_range)
          report($sformatf("bin %0d range %h, want %h", e.bin_number,
                           out_data.bin_range, e.bin_range));
        if (out_data.no_return !== e.no_return)
          report($sformatf("bin %0d no_return %b, want %b", e.bin_number,
                           out_data.no_return, e.no_return));
      end
    end
  end

  function automatic ptsb_pkg::in_t noise_item();
    ptsb_pkg::in_t it;
    it = ptsb_pkg::in_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
    return it;
  endfunction

  function automatic void push_point(int x, int y, int z, bit inv, bit drain = 0);
    beat_t b;
    b.d = noise_item();
    b.d.req_type = REQ_POINT;
    b.d.point_x = 24'(x);
    b.d.point_y = 24'(y);
    b.d.point_z = 24'(z);
    b.d.point_invalid = inv;
    b.drain = drain;
    pending_items.push_back(b);
  endfunction

  function automatic void push_read(int bin_idx, bit drain = 0);
    beat_t b;
    b.d = noise_item();
    b.d.req_type = ptsb_pkg::REQ_READ;
    b.d.read_bin = 9'(bin_idx);
    b.drain = drain;
    pending_items.push_back(b);
  endfunction

  // Mostly points that pass a metre-scale window, some full-scale noise, reads.
  function automatic void push_random(bit drain);
    int roll, rad;
    roll = $urandom_range(0, 99);
    rad = ($urandom_range(0, 3) == 0) ? 8388607 : $urandom_range(1000, 3000000);
    if (roll < 35) begin
      if ($urandom_range(0, 1)) push_read($urandom_range(0, 511), drain);
      else push_read($urandom_range(0, 40) * 8 + $urandom_range(0, 7), drain);
    end else if (roll < 45) begin
      pending_items.push_back('{noise_item(), drain});
    end else begin
      push_point($urandom_range(0, 2 * rad) - rad, $urandom_range(0, 2 * rad) - rad,
                 ($urandom_range(0, 4) == 0) ? int'($urandom()) :
                 $urandom_range(0, 400000) - 200000,
                 $urandom_range(0, 9) == 0, drain);
    end
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || expected_bins.size() > 0 || busy)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all registers back to back, keeping valid high between beats.
  task automatic write_regs(input logic [23:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (3'(i))
        ptsb_pkg::CFG_MIN_HEIGHT:    min_h = v[i];
        ptsb_pkg::CFG_MAX_HEIGHT:    max_h = v[i];
        ptsb_pkg::CFG_RANGE_FLOOR:   rng_lo = v[i];
        ptsb_pkg::CFG_RANGE_CEILING: rng_hi = v[i];
        ptsb_pkg::CFG_ANGLE_START:   ang_lo = v[i][18:0];
        ptsb_pkg::CFG_ANGLE_STOP:    ang_hi = v[i][18:0];
        ptsb_pkg::CFG_ANGLE_STEP:    ang_step = v[i][17:0];
        default:                     fill_val = v[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [23:0] regs [8];
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: coordinate extremes, origin, drops, both ends of the bin range.
    push_point(8388607, 0, 0, 0);
    push_point(-8388608, 0, 0, 0);
    push_point(-8388608, -1, 0, 0);
    push_point(-8388608, 8388607, 8388607, 0);
    push_point(8388607, -8388608, -8388608, 0);
    push_point(0, 0, 0, 0);
    push_point(0, 65536, 0, 0);
    push_point(0, -65536, 0, 0);
    push_point(-65536, 0, 0, 0);
    push_point(65536, 1, 0, 1);
    push_point(65536, 2, 0, 0);
    push_read(179);
    push_read(180);
    push_read(0);
    push_read(359);
    push_read(511);
    push_read(180);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: regs = '{-131072, 131072, 32768, 2621440, -102943, 102943, 2000, 0};
          2: regs = '{24'h800000, 24'h7FFFFF, 0, 24'hFFFFFF, -205887, 205887, 1,
                      24'hFFFFFF};
          3: regs = '{-200000, 200000, 0, 3000000, 0, 50, 0, 24'h123456};
          4: regs = '{24'h800000, 24'h7FFFFF, 0, 24'hFFFFFF, 1000, -1000, 500, 77};
          5: regs = '{24'h800000, 24'h7FFFFF, 0, 24'hFFFFFF, -205887, 205887,
                      205887, 5};
          default: begin
            regs[ptsb_pkg::CFG_MIN_HEIGHT] = 24'(-$urandom_range(0, 300000));
            regs[ptsb_pkg::CFG_MAX_HEIGHT] = 24'($urandom_range(0, 300000));
            regs[ptsb_pkg::CFG_RANGE_FLOOR] = 24'($urandom_range(0, 100000));
            regs[ptsb_pkg::CFG_RANGE_CEILING] = 24'($urandom_range(1000000, 16777215));
            regs[ptsb_pkg::CFG_ANGLE_START] = 24'(-$urandom_range(0, 205887));
            regs[ptsb_pkg::CFG_ANGLE_STOP] = 24'($urandom_range(0, 205887));
            regs[ptsb_pkg::CFG_ANGLE_STEP] = 24'($urandom_range(1, 5000));
            regs[ptsb_pkg::CFG_EMPTY_FILL] = 24'($urandom());
          end
        endcase
        write_regs(regs);
      end
      no_idle = (p == 3);
      for (int k = 0; k < PER_PHASE; k++) push_random(k == PER_PHASE / 2);
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
